// ===== design/tccw_pkg.sv =====
package tccw_pkg;

    localparam int OP_W     = 3;
    localparam int CHAR_W   = 8;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 13;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 8;
    localparam int ADDR_W   = ROW_W + COL_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OP_W-1:0] OP_PUT_CHAR = 3'd0;
    localparam logic [OP_W-1:0] OP_SET_BOTH = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_COL  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_ROW  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ     = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 1'd1;

    localparam logic [COL_W-1:0] COLUMNS_RESET = 8'd80;
    localparam logic [COL_W-1:0] ROWS_RESET    = 8'd25;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        K_PUT,
        K_SET_BOTH,
        K_SET_COL,
        K_SET_ROW,
        K_CLEAR,
        K_READ,
        K_NOP
    } kind_t;

    typedef enum logic [2:0] {
        C_ZERO,
        C_BS,
        C_TAB,
        C_NL,
        C_PRINT,
        C_OTHER
    } char_kind_t;

    typedef struct packed {
        kind_t              kind;
        char_kind_t         char_kind;
        logic [CHAR_W-1:0]  char_code;
        logic [COL_W-1:0]   new_column;
        logic [ROW_W-1:0]   new_row;
        logic [ROW_W-1:0]   read_address;
    } cmd_t;

endpackage

// ===== design/tccw_front.sv =====
module tccw_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tccw_pkg::OP_W-1:0]     op,
    input  logic [tccw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tccw_pkg::COL_W-1:0]    new_column,
    input  logic [tccw_pkg::ROW_W-1:0]    new_row,
    input  logic [tccw_pkg::ROW_W-1:0]    read_address,
    input  logic                          init_busy,
    input  logic                          q_full,
    output logic                          q_push,
    output tccw_pkg::cmd_t                q_cmd
);

    tccw_pkg::kind_t      kind;
    tccw_pkg::char_kind_t char_kind;

    always_comb
    begin
        case (op)
            tccw_pkg::OP_PUT_CHAR: kind = tccw_pkg::K_PUT;
            tccw_pkg::OP_SET_BOTH: kind = tccw_pkg::K_SET_BOTH;
            tccw_pkg::OP_SET_COL:  kind = tccw_pkg::K_SET_COL;
            tccw_pkg::OP_SET_ROW:  kind = tccw_pkg::K_SET_ROW;
            tccw_pkg::OP_CLEAR:    kind = tccw_pkg::K_CLEAR;
            tccw_pkg::OP_READ:     kind = tccw_pkg::K_READ;
            default:               kind = tccw_pkg::K_NOP;
        endcase
    end

    always_comb
    begin
        case (char_code)
            tccw_pkg::CHAR_NUL: char_kind = tccw_pkg::C_ZERO;
            tccw_pkg::CHAR_BS:  char_kind = tccw_pkg::C_BS;
            tccw_pkg::CHAR_TAB: char_kind = tccw_pkg::C_TAB;
            tccw_pkg::CHAR_NL:  char_kind = tccw_pkg::C_NL;
            default:
            begin
                if (char_code >= tccw_pkg::CHAR_SPACE)
                begin
                    char_kind = tccw_pkg::C_PRINT;
                end
                else
                begin
                    char_kind = tccw_pkg::C_OTHER;
                end
            end
        endcase
    end

    assign in_ready = !q_full && !init_busy;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        q_cmd.kind         = kind;
        q_cmd.char_kind    = char_kind;
        q_cmd.char_code    = char_code;
        q_cmd.new_column   = new_column;
        q_cmd.new_row      = new_row;
        q_cmd.read_address = read_address;
    end

endmodule

// ===== design/tccw_queue.sv =====
module tccw_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tccw_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output tccw_pkg::cmd_t pop_cmd,
    output logic           empty
);

    tccw_pkg::cmd_t                   entry_reg [tccw_pkg::QUEUE_DEPTH];
    logic [tccw_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [tccw_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [tccw_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [tccw_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [tccw_pkg::QCNT_W-1:0]      count_reg;
    logic [tccw_pkg::QCNT_W-1:0]      count_next;

    assign full    = (count_reg == tccw_pkg::QCNT_W'(tccw_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/tccw_back.sv =====
module tccw_back #(
    parameter int STORE_CELLS = 8192,
    parameter int TAB_STEP    = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tccw_pkg::cmd_t                  q_cmd,
    input  logic                            q_empty,
    output logic                            q_pop,
    input  logic [tccw_pkg::COL_W-1:0]      columns,
    input  logic [tccw_pkg::COL_W-1:0]      rows,
    output logic                            init_busy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tccw_pkg::CHAR_W-1:0]     read_data,
    output logic [tccw_pkg::COL_W-1:0]      cursor_column,
    output logic [tccw_pkg::ROW_W-1:0]      cursor_row,
    output logic [tccw_pkg::ROW_W-1:0]      scroll_row,
    output logic [tccw_pkg::STATUS_W-1:0]   status
);

    localparam int AW = $clog2(STORE_CELLS);
    localparam int AD = tccw_pkg::ADDR_W;
    localparam int CW = tccw_pkg::COL_W;
    localparam int RW = tccw_pkg::ROW_W;
    localparam logic [AW-1:0] LAST_CELL   = AW'(STORE_CELLS - 1);
    localparam logic [AD-1:0] STORE_LIMIT = AD'(STORE_CELLS);
    localparam logic [CW:0]   TAB_INC     = (CW + 1)'(TAB_STEP);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        R_IDLE,
        R_EXEC,
        R_OUT
    } ret_t;

    state_t                           state_reg, state_next;
    ret_t                             ret_reg, ret_next;
    logic [AW-1:0]                    clear_cnt_reg, clear_cnt_next;
    tccw_pkg::cmd_t                   cmd_reg, cmd_next;
    logic [AD-1:0]                    addr_reg, addr_next;
    logic                             rd_ok_reg, rd_ok_next;
    logic [CW-1:0]                    column_reg, column_next;
    logic [RW-1:0]                    row_reg, row_next;
    logic [RW-1:0]                    scroll_reg, scroll_next;
    logic [tccw_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [tccw_pkg::CHAR_W-1:0]      data_reg, data_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tccw_pkg::CHAR_W-1:0]      out_data_reg, out_data_next;
    logic [CW-1:0]                    out_column_reg, out_column_next;
    logic [RW-1:0]                    out_row_reg, out_row_next;
    logic [RW-1:0]                    out_scroll_reg, out_scroll_next;
    logic [tccw_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;

    logic [tccw_pkg::CHAR_W-1:0]      store_mem [STORE_CELLS];
    logic [tccw_pkg::CHAR_W-1:0]      mem_rdata_reg;
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic [tccw_pkg::CHAR_W-1:0]      mem_wdata;
    logic [AW-1:0]                    mem_raddr;

    logic [AD-1:0]                    cell_prod;
    logic [AD-1:0]                    raddr_ext;
    logic                             addr_ok;
    logic [CW:0]                      col_calc;
    logic [1:0]                       row_step;
    logic [RW-1:0]                    row_calc;
    logic [RW:0]                      scroll_limit;

    assign cell_prod = AD'(row_reg) * AD'(columns);
    assign raddr_ext = AD'(q_cmd.read_address);
    assign mem_raddr = raddr_ext[AW-1:0];
    assign addr_ok   = (addr_reg < STORE_LIMIT);

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign init_busy = (state_reg == S_CLEAR) && (ret_reg == R_IDLE);

    always_comb
    begin
        col_calc = {1'b0, column_reg};
        row_step = 2'd0;
        case (cmd_reg.char_kind)
            tccw_pkg::C_BS:
            begin
                if (column_reg != '0)
                begin
                    col_calc = {1'b0, column_reg} - 1'b1;
                end
            end
            tccw_pkg::C_TAB:   col_calc = {1'b0, column_reg} + TAB_INC;
            tccw_pkg::C_NL:
            begin
                col_calc = '0;
                row_step = 2'd1;
            end
            tccw_pkg::C_PRINT: col_calc = {1'b0, column_reg} + 1'b1;
            default:           col_calc = {1'b0, column_reg};
        endcase
        if (col_calc >= {1'b0, columns})
        begin
            col_calc = '0;
            row_step = row_step + 1'b1;
        end
        row_calc     = row_reg + RW'(row_step);
        scroll_limit = (RW + 1)'(rows) + {1'b0, scroll_reg};
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        clear_cnt_next  = clear_cnt_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        rd_ok_next      = rd_ok_reg;
        column_next     = column_reg;
        row_next        = row_reg;
        scroll_next     = scroll_reg;
        status_next     = status_reg;
        data_next       = data_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        out_scroll_next = out_scroll_reg;
        out_status_next = out_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = clear_cnt_reg;
        mem_wdata       = tccw_pkg::CHAR_SPACE;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (clear_cnt_reg == LAST_CELL)
                begin
                    case (ret_reg)
                        R_EXEC:  state_next = S_EXEC;
                        R_OUT:   state_next = S_OUT;
                        default: state_next = S_IDLE;
                    endcase
                end
                else
                begin
                    clear_cnt_next = clear_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next   = q_cmd;
                    addr_next  = cell_prod + AD'(column_reg);
                    rd_ok_next = (raddr_ext < STORE_LIMIT);
                    data_next  = '0;
                    if (q_cmd.kind == tccw_pkg::K_PUT && q_cmd.char_kind == tccw_pkg::C_ZERO)
                    begin
                        status_next = tccw_pkg::STATUS_ZERO;
                    end
                    else
                    begin
                        status_next = tccw_pkg::STATUS_DONE;
                    end
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                case (cmd_reg.kind)
                    tccw_pkg::K_PUT:
                    begin
                        if (cmd_reg.char_kind == tccw_pkg::C_ZERO)
                        begin
                            state_next = S_OUT;
                        end
                        else if (!addr_ok)
                        begin
                            column_next    = '0;
                            row_next       = '0;
                            scroll_next    = '0;
                            addr_next      = '0;
                            status_next    = tccw_pkg::STATUS_CLEARED;
                            clear_cnt_next = '0;
                            ret_next       = R_EXEC;
                            state_next     = S_CLEAR;
                        end
                        else
                        begin
                            if (cmd_reg.char_kind == tccw_pkg::C_BS && column_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_reg[AW-1:0] - 1'b1;
                                mem_wdata = tccw_pkg::CHAR_SPACE;
                            end
                            else if (cmd_reg.char_kind == tccw_pkg::C_PRINT)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = addr_reg[AW-1:0];
                                mem_wdata = cmd_reg.char_code;
                            end
                            column_next = col_calc[CW-1:0];
                            row_next    = row_calc;
                            if ({1'b0, row_calc} >= scroll_limit)
                            begin
                                scroll_next = scroll_reg + 1'b1;
                            end
                        end
                    end
                    tccw_pkg::K_SET_BOTH:
                    begin
                        column_next = cmd_reg.new_column;
                        row_next    = cmd_reg.new_row;
                    end
                    tccw_pkg::K_SET_COL: column_next = cmd_reg.new_column;
                    tccw_pkg::K_SET_ROW: row_next    = cmd_reg.new_row;
                    tccw_pkg::K_CLEAR:
                    begin
                        column_next    = '0;
                        row_next       = '0;
                        scroll_next    = '0;
                        clear_cnt_next = '0;
                        ret_next       = R_OUT;
                        state_next     = S_CLEAR;
                    end
                    tccw_pkg::K_READ:
                    begin
                        data_next = rd_ok_reg ? mem_rdata_reg : '0;
                    end
                    default: data_next = '0;
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = data_reg;
                    out_column_next = column_reg;
                    out_row_next    = row_reg;
                    out_scroll_next = scroll_reg;
                    out_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            ret_reg        <= R_IDLE;
            clear_cnt_reg  <= '0;
            cmd_reg        <= '0;
            addr_reg       <= '0;
            rd_ok_reg      <= 1'b0;
            column_reg     <= '0;
            row_reg        <= '0;
            scroll_reg     <= '0;
            status_reg     <= tccw_pkg::STATUS_DONE;
            data_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
            out_scroll_reg <= '0;
            out_status_reg <= tccw_pkg::STATUS_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            clear_cnt_reg  <= clear_cnt_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            rd_ok_reg      <= rd_ok_next;
            column_reg     <= column_next;
            row_reg        <= row_next;
            scroll_reg     <= scroll_next;
            status_reg     <= status_next;
            data_reg       <= data_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
            out_scroll_reg <= out_scroll_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= store_mem[mem_raddr];
    end

    assign out_valid     = out_valid_reg;
    assign read_data     = out_data_reg;
    assign cursor_column = out_column_reg;
    assign cursor_row    = out_row_reg;
    assign scroll_row    = out_scroll_reg;
    assign status        = out_status_reg;

`ifndef SYNTHESIS
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("store written while idle");

    a_put_column_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && cmd_reg.kind == tccw_pkg::K_PUT
            && status_reg != tccw_pkg::STATUS_ZERO)
        |-> (column_reg < columns || column_reg == '0))
        else $error("column left beyond line width after put char");

    a_clear_sweep_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && clear_cnt_reg != LAST_CELL)
        |=> (state_reg == S_CLEAR && clear_cnt_reg == $past(clear_cnt_reg) + 1'b1))
        else $error("clear sweep broke off early");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result dropped while output stalled");

    a_no_pop_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        init_busy |-> !q_pop)
        else $error("transaction taken during initial clear");
`endif

endmodule

// ===== design/text_console_cursor_writer_core.sv =====
// Text console cursor writer.
// Input channel (in_valid/in_ready): one transaction carries op, char_code,
// new_column, new_row and read_address. Output channel (out_valid/out_ready)
// returns one transaction per input: read_data, cursor_column, cursor_row,
// scroll_row and status. Configuration: cfg_write with cfg_index 0 (columns)
// or 1 (rows) and cfg_data; write only while the block is idle.
// A transaction that needs no clear passes through the queue and then the
// back end sequencer steps: fetch and address multiply, execute, output load.
// The sequencer takes no new transaction until it has loaded the last result.
// A clear (op 4) sweeps the character store to spaces, one cell per cycle; a
// put char whose cell lies beyond the store sweeps it too, then runs at cell 0.
// Reset: columns 80, rows 25, cursor and scroll zero; the store is then swept
// to spaces with in_ready low.
// A stalled receiver holds one result in the output register and one in the back
// end; two more queue between front and back end before in_ready drops.
module text_console_cursor_writer_core #(
    parameter int STORE_CELLS = 8192,
    parameter int TAB_STEP    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tccw_pkg::OP_W-1:0]         op,
    input  logic [tccw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tccw_pkg::COL_W-1:0]        new_column,
    input  logic [tccw_pkg::ROW_W-1:0]        new_row,
    input  logic [tccw_pkg::ROW_W-1:0]        read_address,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tccw_pkg::CHAR_W-1:0]       read_data,
    output logic [tccw_pkg::COL_W-1:0]        cursor_column,
    output logic [tccw_pkg::ROW_W-1:0]        cursor_row,
    output logic [tccw_pkg::ROW_W-1:0]        scroll_row,
    output logic [tccw_pkg::STATUS_W-1:0]     status,
    input  logic                              cfg_write,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tccw_pkg::CFG_W-1:0]        cfg_data
);

    logic [tccw_pkg::COL_W-1:0] columns_reg, columns_next;
    logic [tccw_pkg::COL_W-1:0] rows_reg, rows_next;

    tccw_pkg::cmd_t  push_cmd;
    tccw_pkg::cmd_t  pop_cmd;
    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    logic            init_busy;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                tccw_pkg::REG_COLUMNS: columns_next = cfg_data;
                tccw_pkg::REG_ROWS:    rows_next    = cfg_data;
                default:               columns_next = columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= tccw_pkg::COLUMNS_RESET;
            rows_reg    <= tccw_pkg::ROWS_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    tccw_front u_front (
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .char_code    (char_code),
        .new_column   (new_column),
        .new_row      (new_row),
        .read_address (read_address),
        .init_busy    (init_busy),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    tccw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty)
    );

    tccw_back #(
        .STORE_CELLS (STORE_CELLS),
        .TAB_STEP    (TAB_STEP)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_cmd         (pop_cmd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .columns       (columns_reg),
        .rows          (rows_reg),
        .init_busy     (init_busy),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .scroll_row    (scroll_row),
        .status        (status)
    );

endmodule

// ===== test/console_screen_checker.sv =====
`timescale 1ns / 100ps
module console_screen_checker #(
    parameter int STORE_CELLS = 8192,
    parameter int TAB_STEP    = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [tccw_pkg::OP_W-1:0]         op,
    input  logic [tccw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tccw_pkg::COL_W-1:0]        new_column,
    input  logic [tccw_pkg::ROW_W-1:0]        new_row,
    input  logic [tccw_pkg::ROW_W-1:0]        read_address,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic [tccw_pkg::CHAR_W-1:0]       read_data,
    input  logic [tccw_pkg::COL_W-1:0]        cursor_column,
    input  logic [tccw_pkg::ROW_W-1:0]        cursor_row,
    input  logic [tccw_pkg::ROW_W-1:0]        scroll_row,
    input  logic [tccw_pkg::STATUS_W-1:0]     status,
    input  logic                              cfg_write,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tccw_pkg::CFG_W-1:0]        cfg_data,
    output int                                mismatches,
    output int                                outstanding
);

    localparam int ROW_SPAN = 1 << tccw_pkg::ROW_W;

    typedef struct packed {
        logic [tccw_pkg::CHAR_W-1:0]   data;
        logic [tccw_pkg::COL_W-1:0]    column;
        logic [tccw_pkg::ROW_W-1:0]    row;
        logic [tccw_pkg::ROW_W-1:0]    scroll;
        logic [tccw_pkg::STATUS_W-1:0] status;
    } console_view_t;

    logic [tccw_pkg::CHAR_W-1:0] screen [STORE_CELLS];
    int unsigned       col_now;
    int unsigned       row_now;
    int unsigned       scroll_now;
    int unsigned       width_cfg;
    int unsigned       height_cfg;
    int                failures;
    console_view_t     awaited_views [$];
    console_view_t     oldest;

    function automatic void wipe_screen();
        for (int i = 0; i < STORE_CELLS; i++)
        begin
            screen[i] = tccw_pkg::CHAR_SPACE;
        end
        col_now    = 0;
        row_now    = 0;
        scroll_now = 0;
    endfunction

    function automatic console_view_t advance_console(
        input logic [tccw_pkg::OP_W-1:0]   code,
        input logic [tccw_pkg::CHAR_W-1:0] ch,
        input logic [tccw_pkg::COL_W-1:0]  col,
        input logic [tccw_pkg::ROW_W-1:0]  row,
        input logic [tccw_pkg::ROW_W-1:0]  addr
    );
        console_view_t view;
        int unsigned   cell_idx;
        int unsigned   next_col;
        view = '0;
        case (code)
            tccw_pkg::OP_PUT_CHAR:
            begin
                if (ch == tccw_pkg::CHAR_NUL)
                begin
                    view.status = tccw_pkg::STATUS_ZERO;
                end
                else
                begin
                    cell_idx = row_now * width_cfg + col_now;
                    if (cell_idx >= STORE_CELLS)
                    begin
                        wipe_screen();
                        view.status = tccw_pkg::STATUS_CLEARED;
                        cell_idx = 0;
                    end
                    next_col = col_now;
                    if (ch == tccw_pkg::CHAR_BS && next_col != 0)
                    begin
                        next_col--;
                        screen[cell_idx - 1] = tccw_pkg::CHAR_SPACE;
                    end
                    else if (ch == tccw_pkg::CHAR_TAB)
                    begin
                        next_col += TAB_STEP;
                    end
                    else if (ch == tccw_pkg::CHAR_NL)
                    begin
                        next_col = 0;
                        row_now = (row_now + 1) % ROW_SPAN;
                    end
                    else if (ch >= tccw_pkg::CHAR_SPACE)
                    begin
                        screen[cell_idx] = ch;
                        next_col++;
                    end
                    // wrap compares the full column, before truncation
                    if (next_col >= width_cfg)
                    begin
                        next_col = 0;
                        row_now = (row_now + 1) % ROW_SPAN;
                    end
                    col_now = next_col % 256;
                    if (row_now >= height_cfg + scroll_now)
                    begin
                        scroll_now = (scroll_now + 1) % ROW_SPAN;
                    end
                end
            end
            tccw_pkg::OP_SET_BOTH:
            begin
                col_now = col;
                row_now = row;
            end
            tccw_pkg::OP_SET_COL:
            begin
                col_now = col;
            end
            tccw_pkg::OP_SET_ROW:
            begin
                row_now = row;
            end
            tccw_pkg::OP_CLEAR:
            begin
                wipe_screen();
            end
            tccw_pkg::OP_READ:
            begin
                if (addr < STORE_CELLS)
                begin
                    view.data = screen[addr];
                end
            end
            default:
            begin
            end
        endcase
        view.column = tccw_pkg::COL_W'(col_now);
        view.row    = tccw_pkg::ROW_W'(row_now);
        view.scroll = tccw_pkg::ROW_W'(scroll_now);
        return view;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wipe_screen();
            width_cfg  = tccw_pkg::COLUMNS_RESET;
            height_cfg = tccw_pkg::ROWS_RESET;
            awaited_views.delete();
            failures = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_views.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    failures++;
                end
                else
                begin
                    oldest = awaited_views.pop_front();
                    if (read_data !== oldest.data)
                    begin
                        $error("read_data: expected %0d, got %0d", oldest.data, read_data);
                        failures++;
                    end
                    if (cursor_column !== oldest.column)
                    begin
                        $error("cursor_column: expected %0d, got %0d",
                               oldest.column, cursor_column);
                        failures++;
                    end
                    if (cursor_row !== oldest.row)
                    begin
                        $error("cursor_row: expected %0d, got %0d", oldest.row, cursor_row);
                        failures++;
                    end
                    if (scroll_row !== oldest.scroll)
                    begin
                        $error("scroll_row: expected %0d, got %0d", oldest.scroll, scroll_row);
                        failures++;
                    end
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, got %0d", oldest.status, status);
                        failures++;
                    end
                end
            end
            if (cfg_write)
            begin
                if (cfg_index == tccw_pkg::REG_COLUMNS)
                begin
                    width_cfg = cfg_data;
                end
                else if (cfg_index == tccw_pkg::REG_ROWS)
                begin
                    height_cfg = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_views.push_back(advance_console(op, char_code, new_column,
                                                        new_row, read_address));
            end
        end
        mismatches  <= failures;
        outstanding <= awaited_views.size();
    end

endmodule

// ===== test/text_console_cursor_writer_core_tb.sv =====
`timescale 1ns / 100ps
module text_console_cursor_writer_core_tb;

    localparam int STORE_CELLS      = 8192;
    localparam int TAB_STEP         = 8;
    localparam int PHASES           = 7;
    localparam int RANDOM_PER_PHASE = 230;

    localparam logic [tccw_pkg::OP_W-1:0]   OP_SPARE_LOW  = 3'd6;
    localparam logic [tccw_pkg::OP_W-1:0]   OP_SPARE_HIGH = 3'd7;
    localparam logic [tccw_pkg::CHAR_W-1:0] CHAR_SOH      = 8'h01;
    localparam logic [tccw_pkg::CHAR_W-1:0] CHAR_LAST_CTL = 8'h1F;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              in_valid     = 1'b0;
    logic                              in_ready;
    logic [tccw_pkg::OP_W-1:0]         op           = '0;
    logic [tccw_pkg::CHAR_W-1:0]       char_code    = '0;
    logic [tccw_pkg::COL_W-1:0]        new_column   = '0;
    logic [tccw_pkg::ROW_W-1:0]        new_row      = '0;
    logic [tccw_pkg::ROW_W-1:0]        read_address = '0;
    logic                              out_valid;
    logic                              out_ready    = 1'b0;
    logic [tccw_pkg::CHAR_W-1:0]       read_data;
    logic [tccw_pkg::COL_W-1:0]        cursor_column;
    logic [tccw_pkg::ROW_W-1:0]        cursor_row;
    logic [tccw_pkg::ROW_W-1:0]        scroll_row;
    logic [tccw_pkg::STATUS_W-1:0]     status;
    logic                              cfg_write    = 1'b0;
    logic [tccw_pkg::CFG_IDX_W-1:0]    cfg_index    = '0;
    logic [tccw_pkg::CFG_W-1:0]        cfg_data     = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int phase_cols [PHASES] = '{80, 1, 255, 0, 40, 255, 1};
    int phase_rows [PHASES] = '{25, 1, 255, 7, 12, 1, 255};

    always #4 clk = ~clk;

    text_console_cursor_writer_core #(
        .STORE_CELLS (STORE_CELLS),
        .TAB_STEP    (TAB_STEP)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .char_code     (char_code),
        .new_column    (new_column),
        .new_row       (new_row),
        .read_address  (read_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .scroll_row    (scroll_row),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    console_screen_checker #(
        .STORE_CELLS (STORE_CELLS),
        .TAB_STEP    (TAB_STEP)
    ) screen_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .char_code     (char_code),
        .new_column    (new_column),
        .new_row       (new_row),
        .read_address  (read_address),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_data     (read_data),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .scroll_row    (scroll_row),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // hold the transaction until accepted, then maybe drop valid for a while
    task automatic send(
        input logic [tccw_pkg::OP_W-1:0]   code,
        input logic [tccw_pkg::CHAR_W-1:0] ch,
        input logic [tccw_pkg::COL_W-1:0]  col,
        input logic [tccw_pkg::ROW_W-1:0]  row,
        input logic [tccw_pkg::ROW_W-1:0]  addr
    );
        in_valid     <= 1'b1;
        op           <= code;
        char_code    <= ch;
        new_column   <= col;
        new_row      <= row;
        read_address <= addr;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
    endtask

    task automatic random_item();
        int unsigned                   pick;
        int unsigned                   char_pick;
        logic [tccw_pkg::OP_W-1:0]     code;
        logic [tccw_pkg::CHAR_W-1:0]   ch;
        logic [tccw_pkg::ROW_W-1:0]    row;
        logic [tccw_pkg::ROW_W-1:0]    addr;
        pick = $urandom_range(999);
        if (pick < 650)
            code = tccw_pkg::OP_PUT_CHAR;
        else if (pick < 730)
            code = tccw_pkg::OP_SET_BOTH;
        else if (pick < 780)
            code = tccw_pkg::OP_SET_COL;
        else if (pick < 830)
            code = tccw_pkg::OP_SET_ROW;
        else if (pick < 985)
            code = tccw_pkg::OP_READ;
        else if (pick < 988)
            code = tccw_pkg::OP_CLEAR;
        else
            code = tccw_pkg::OP_W'($urandom_range(OP_SPARE_LOW, OP_SPARE_HIGH));
        char_pick = $urandom_range(99);
        if (char_pick < 14)
            ch = tccw_pkg::CHAR_NL;
        else if (char_pick < 19)
            ch = tccw_pkg::CHAR_TAB;
        else if (char_pick < 25)
            ch = tccw_pkg::CHAR_BS;
        else if (char_pick < 28)
            ch = tccw_pkg::CHAR_NUL;
        else if (char_pick < 31)
            ch = tccw_pkg::CHAR_W'($urandom_range(CHAR_SOH, CHAR_LAST_CTL));
        else
            ch = tccw_pkg::CHAR_W'($urandom_range(tccw_pkg::CHAR_SPACE, 255));
        // mostly rows that keep the cursor inside the store
        if ($urandom_range(15) == 0)
            row = tccw_pkg::ROW_W'($urandom_range(STORE_CELLS - 1));
        else
            row = tccw_pkg::ROW_W'($urandom_range(30));
        if ($urandom_range(1) == 0)
            addr = tccw_pkg::ROW_W'($urandom_range(1023));
        else
            addr = tccw_pkg::ROW_W'($urandom_range(STORE_CELLS - 1));
        send(code, ch, tccw_pkg::COL_W'($urandom_range(255)), row, addr);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_regs(input logic [tccw_pkg::CFG_W-1:0] cols,
                              input logic [tccw_pkg::CFG_W-1:0] rows);
        cfg_write <= 1'b1;
        cfg_index <= tccw_pkg::REG_COLUMNS;
        cfg_data  <= cols;
        @(posedge clk);
        cfg_index <= tccw_pkg::REG_ROWS;
        cfg_data  <= rows;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        #50_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int p;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (p = 0; p < PHASES; p++)
        begin
            if (p != 0)
            begin
                drain();
                write_regs(tccw_pkg::CFG_W'(phase_cols[p]), tccw_pkg::CFG_W'(phase_rows[p]));
            end
            case (idle_mode_t'(p % 4))
                IDLE_NONE:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                IDLE_SEND:
                begin
                    send_idle_pct  = 82;
                    recv_stall_pct = 0;
                end
                IDLE_RECV:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 82;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            if (p == 0)
            begin
                send(tccw_pkg::OP_READ, tccw_pkg::CHAR_NUL, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, 8'h41, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, 8'hFF, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_SPACE, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_NUL, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_BS, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_TAB, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, CHAR_SOH, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_NL, '0, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_BS, '0, '0, '0);
                send(tccw_pkg::OP_SET_COL, tccw_pkg::CHAR_NUL, 8'd79, '0, '0);
                send(tccw_pkg::OP_PUT_CHAR, 8'h78, '0, '0, '0);
                send(tccw_pkg::OP_SET_BOTH, tccw_pkg::CHAR_NUL, '1, 13'd3, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_TAB, '0, '0, '0);
                send(tccw_pkg::OP_SET_ROW, tccw_pkg::CHAR_NUL, '0, 13'd24, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_NL, '0, '0, '0);
                send(tccw_pkg::OP_READ, tccw_pkg::CHAR_NUL, '0, '0, '0);
                // last cell of the store, then the auto-clear past it
                send(tccw_pkg::OP_SET_BOTH, tccw_pkg::CHAR_NUL, 8'd31, 13'd102, '0);
                send(tccw_pkg::OP_PUT_CHAR, 8'h5A, '0, '0, '0);
                send(tccw_pkg::OP_READ, tccw_pkg::CHAR_NUL, '0, '0, '1);
                send(tccw_pkg::OP_PUT_CHAR, 8'h51, '0, '0, '0);
                send(tccw_pkg::OP_SET_ROW, tccw_pkg::CHAR_NUL, '0, '1, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_NUL, '0, '0, '0);
                send(OP_SPARE_LOW, tccw_pkg::CHAR_NUL, '0, '0, '0);
                send(OP_SPARE_HIGH, tccw_pkg::CHAR_NUL, '0, '0, '0);
                send(tccw_pkg::OP_CLEAR, tccw_pkg::CHAR_NUL, '0, '0, '0);
                send(tccw_pkg::OP_READ, tccw_pkg::CHAR_NUL, '0, '0, '0);
            end
            if (phase_cols[p] == 0)
            begin
                // row overflow without an auto-clear needs a column count of zero or one
                send(tccw_pkg::OP_SET_BOTH, tccw_pkg::CHAR_NUL, '0, '1, '0);
                send(tccw_pkg::OP_PUT_CHAR, tccw_pkg::CHAR_NL, '0, '0, '0);
            end
            repeat (RANDOM_PER_PHASE) random_item();
        end
        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
